/* rtl/lca_pkg.sv */
// Package: shared constants, action codes and result type for the LCA core.
package lca_pkg;

  localparam int MaxNodesDef = 16384;
  localparam int LevelsDef   = 14;
  localparam int NodeW       = 14;
  localparam int ActW        = 2;

  localparam logic [ActW-1:0] ActClear = 2'd0;
  localparam logic [ActW-1:0] ActEdge  = 2'd1;
  localparam logic [ActW-1:0] ActQuery = 2'd2;

  typedef struct packed {
    logic             valid;
    logic             found;
    logic [NodeW-1:0] ancestor;
  } lca_res_t;

endpackage

/* rtl/lca_mem.sv */
// Jump table storage: one write port, one registered read port.
module lca_mem import lca_pkg::*; #(
  parameter int Depth = MaxNodesDef * LevelsDef,
  parameter int DataW = 15,
  parameter int AddrW = $clog2(MaxNodesDef * LevelsDef)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/lca_seq.sv */
// Sequencer: clearing, table rebuild and query walk over the shared read port.
module lca_seq import lca_pkg::*; #(
  parameter int MaxNodes = MaxNodesDef,
  parameter int Levels   = LevelsDef,
  parameter int NW       = $clog2(MaxNodes),
  parameter int AddrW    = $clog2(MaxNodes * Levels)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ActW-1:0]  action_i,
  input  logic [NodeW-1:0] node_a_i,
  input  logic [NodeW-1:0] node_b_i,
  input  logic             out_ready_i,
  output lca_res_t         res_o,
  output logic             we_o,
  output logic [AddrW-1:0] waddr_o,
  output logic [NW:0]      wdata_o,
  output logic [AddrW-1:0] raddr_o,
  input  logic [NW:0]      rdata_i
);

  localparam int LW = (Levels > 1) ? $clog2(Levels) : 1;
  localparam logic [LW-1:0] LvlTop = LW'(Levels - 1);
  localparam logic [NW-1:0] NodeLast = NW'(MaxNodes - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_RBRD = 4'd2;
  localparam logic [3:0] S_RBE  = 4'd3;
  localparam logic [3:0] S_RBR  = 4'd4;
  localparam logic [3:0] S_DURD = 4'd5;
  localparam logic [3:0] S_DUCK = 4'd6;
  localparam logic [3:0] S_LFRD = 4'd7;
  localparam logic [3:0] S_LFCK = 4'd8;
  localparam logic [3:0] S_UPRU = 4'd9;
  localparam logic [3:0] S_UPRV = 4'd10;
  localparam logic [3:0] S_UPCK = 4'd11;
  localparam logic [3:0] S_PARD = 4'd12;
  localparam logic [3:0] S_PACK = 4'd13;
  localparam logic [3:0] S_OUT  = 4'd14;

  function automatic logic [AddrW-1:0] addr_of(logic [LW-1:0] lvl, logic [NW-1:0] node);
    return AddrW'(lvl) * AddrW'(MaxNodes) + AddrW'(node);
  endfunction

  logic [3:0]        st_q, st_d;
  logic [LW-1:0]     lvl_q, lvl_d;
  logic [NW-1:0]     cnt_q, cnt_d;
  logic [NW-1:0]     x_q, x_d, y_q, y_d, ua_q, ua_d, vb_q, vb_d, ru_q, ru_d;
  logic [NW-1:0]     anc_q, anc_d;
  logic [Levels-1:0] d_q, d_d, du_q, du_d, diff_q, diff_d;
  logic              side_q, side_d, stale_q, stale_d, fnd_q, fnd_d;
  logic [NW:0]       eu_q, eu_d;

  logic              rd_vld;
  logic [NW-1:0]     rd_id;
  logic [NW-1:0]     x_new;
  logic [Levels-1:0] d_new;
  logic              ids_ok;

  assign rd_vld = rdata_i[NW];
  assign rd_id  = rdata_i[NW-1:0];
  assign ids_ok = (32'(node_a_i) < 32'(MaxNodes)) && (32'(node_b_i) < 32'(MaxNodes));
  assign in_stall_o = (st_q != S_IDLE);

  always_comb begin
    st_d = st_q; lvl_d = lvl_q; cnt_d = cnt_q; x_d = x_q; y_d = y_q;
    ua_d = ua_q; vb_d = vb_q; ru_d = ru_q; anc_d = anc_q; d_d = d_q;
    du_d = du_q; diff_d = diff_q; side_d = side_q; stale_d = stale_q;
    fnd_d = fnd_q; eu_d = eu_q;
    we_o = 1'b0; waddr_o = '0; wdata_o = '0; raddr_o = '0;
    res_o = '0;
    x_new = x_q; d_new = d_q;
    unique case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          priority if (action_i == ActClear) begin
            cnt_d = '0; stale_d = 1'b1; st_d = S_CLR;
          end else if (action_i == ActEdge) begin
            if (ids_ok) begin
              we_o = 1'b1;
              waddr_o = addr_of('0, NW'(node_b_i));
              wdata_o = {1'b1, NW'(node_a_i)};
              stale_d = 1'b1;
            end
          end else if (action_i == ActQuery) begin
            ua_d = NW'(node_a_i); vb_d = NW'(node_b_i);
            x_d = NW'(node_a_i); side_d = 1'b0; d_d = '0; lvl_d = LvlTop;
            cnt_d = '0;
            if (!ids_ok) begin
              anc_d = '0; fnd_d = 1'b0; st_d = S_OUT;
            end else if (stale_q && Levels > 1) begin
              lvl_d = LW'(1); st_d = S_RBRD;
            end else begin
              stale_d = 1'b0; st_d = S_DURD;
            end
          end else begin
            st_d = S_IDLE;
          end
        end
      end
      S_CLR: begin
        we_o = 1'b1;
        waddr_o = addr_of('0, cnt_q);
        cnt_d = cnt_q + NW'(1);
        if (cnt_q == NodeLast) st_d = S_IDLE;
      end
      S_RBRD: begin
        raddr_o = addr_of(lvl_q - LW'(1), cnt_q);
        st_d = S_RBE;
      end
      S_RBE, S_RBR: begin
        raddr_o = addr_of(lvl_q - LW'(1), rd_id);
        if (st_q == S_RBE && rd_vld) begin
          st_d = S_RBR;
        end else begin
          we_o = 1'b1;
          waddr_o = addr_of(lvl_q, cnt_q);
          wdata_o = (st_q == S_RBR) ? rdata_i : '0;
          st_d = S_RBRD;
          cnt_d = cnt_q + NW'(1);
          if (cnt_q == NodeLast) begin
            cnt_d = '0;
            if (lvl_q == LvlTop) begin
              stale_d = 1'b0; lvl_d = LvlTop; st_d = S_DURD;
            end else begin
              lvl_d = lvl_q + LW'(1);
            end
          end
        end
      end
      S_DURD: begin
        raddr_o = addr_of(lvl_q, x_q);
        st_d = S_DUCK;
      end
      S_DUCK: begin
        if (rd_vld) begin
          x_new = rd_id;
          d_new = d_q | (Levels'(1) << lvl_q);
        end
        x_d = x_new; d_d = d_new;
        lvl_d = lvl_q - LW'(1);
        st_d = S_DURD;
        if (lvl_q == '0) begin
          if (!side_q) begin
            du_d = d_new; ru_d = x_new; x_d = vb_q; side_d = 1'b1;
            d_d = '0; lvl_d = LvlTop;
          end else if (ru_q != x_new) begin
            anc_d = '0; fnd_d = 1'b0; st_d = S_OUT;
          end else begin
            lvl_d = '0; st_d = S_LFRD;
            if (du_q >= d_new) begin
              x_d = ua_q; diff_d = du_q - d_new; side_d = 1'b0;
            end else begin
              x_d = vb_q; diff_d = d_new - du_q; side_d = 1'b1;
            end
          end
        end
      end
      S_LFRD: begin
        raddr_o = addr_of(lvl_q, x_q);
        st_d = S_LFCK;
      end
      S_LFCK: begin
        if (diff_q[lvl_q] && rd_vld) x_new = rd_id;
        x_d = x_new;
        lvl_d = lvl_q + LW'(1);
        st_d = S_LFRD;
        if (lvl_q == LvlTop) begin
          if (!side_q) begin
            x_d = x_new; y_d = vb_q;
          end else begin
            x_d = ua_q; y_d = x_new;
          end
          lvl_d = LvlTop;
          if ((side_q ? ua_q : x_new) == (side_q ? x_new : vb_q)) begin
            anc_d = x_new; fnd_d = 1'b1; st_d = S_OUT;
          end else begin
            st_d = S_UPRU;
          end
        end
      end
      S_UPRU: begin
        raddr_o = addr_of(lvl_q, x_q);
        st_d = S_UPRV;
      end
      S_UPRV: begin
        raddr_o = addr_of(lvl_q, y_q);
        eu_d = rdata_i;
        st_d = S_UPCK;
      end
      S_UPCK: begin
        if (eu_q[NW] && rd_vld && (eu_q[NW-1:0] != rd_id)) begin
          x_d = eu_q[NW-1:0]; y_d = rd_id;
        end
        lvl_d = lvl_q - LW'(1);
        st_d = (lvl_q == '0) ? S_PARD : S_UPRU;
      end
      S_PARD: begin
        raddr_o = addr_of('0, x_q);
        st_d = S_PACK;
      end
      S_PACK: begin
        anc_d = rd_vld ? rd_id : '0;
        fnd_d = rd_vld;
        st_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          res_o.valid = 1'b1;
          res_o.found = fnd_q;
          res_o.ancestor = NodeW'(anc_q);
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR;
      cnt_q <= '0;
      lvl_q <= '0;
      stale_q <= 1'b1;
      side_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      lvl_q <= lvl_d;
      stale_q <= stale_d;
      side_q <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; ua_q <= ua_d; vb_q <= vb_d; ru_q <= ru_d;
    anc_q <= anc_d; d_q <= d_d; du_q <= du_d; diff_q <= diff_d;
    fnd_q <= fnd_d; eu_q <= eu_d;
  end

endmodule

/* rtl/lowest_common_ancestor_core.sv */
// Top level: LCA core with binary-lifting jump table and result register.
// An edge transfer is written in the cycle it is taken. A clear rewrites level 0
// for every node, and after reset the same clearing pass runs before the first
// item is taken. A query that follows an edge or clear first rebuilds the table,
// every node at each level above level 0, then walks it: both depths, the lift,
// the joint climb and, where needed, a parent read. All table reads go through
// one memory read port. The result waits in an output register.
module lowest_common_ancestor_core import lca_pkg::*; #(
  parameter int MaxNodes = MaxNodesDef,
  parameter int Levels   = LevelsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ActW-1:0]  action_i,
  input  logic [NodeW-1:0] node_a_i,
  input  logic [NodeW-1:0] node_b_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [NodeW-1:0] ancestor_o,
  output logic             found_o
);

  localparam int NW    = $clog2(MaxNodes);
  localparam int AddrW = $clog2(MaxNodes * Levels);

  lca_res_t         res;
  logic             out_ready;
  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [NW:0]      wdata, rdata;
  logic             out_valid_q;
  logic [NodeW-1:0] ancestor_q;
  logic             found_q;

  assign out_ready = !out_valid_q || !out_stall_i;

  lca_seq #(.MaxNodes(MaxNodes), .Levels(Levels), .NW(NW), .AddrW(AddrW)) u_seq (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .node_a_i, .node_b_i,
    .out_ready_i(out_ready), .res_o(res),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata), .raddr_o(raddr), .rdata_i(rdata)
  );

  lca_mem #(.Depth(MaxNodes * Levels), .DataW(NW + 1), .AddrW(AddrW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      ancestor_q <= res.ancestor;
      found_q <= res.found;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ancestor_o  = ancestor_q;
  assign found_o     = found_q;

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && !res.found |-> res.ancestor == '0)
    else $error("not found result carries nonzero ancestor");

  a_busy_after_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == ActClear || action_i == ActQuery)
    |=> in_stall_o)
    else $error("clear or query transfer did not start a busy phase");

  a_res_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> out_ready && in_stall_o)
    else $error("result issued while output register held");

endmodule

/* dv/tb.sv */
// Testbench for the LCA core: random forests, directed corner queries, scoreboard check.
`timescale 1ns / 1ps

module tb;
  import lca_pkg::*;

  localparam logic [ActW-1:0] ActIgnored = 2'd3;
  localparam int TableDepth = MaxNodesDef * LevelsDef;
  localparam longint CycleLimit = 12_000_000;

  typedef struct {
    logic [ActW-1:0]  act;
    logic [NodeW-1:0] a;
    logic [NodeW-1:0] b;
  } lca_item_t;

  class lca_scoreboard;
    logic [16:0] jump [TableDepth];
    bit          stale;
    lca_res_t    pending_q [$];
    int          errors;

    function new();
      errors = 0;
      clear_forest();
    endfunction

    function void clear_forest();
      foreach (jump[i]) jump[i] = '0;
      stale = 1'b1;
    endfunction

    function void rebuild();
      logic [16:0] e;
      for (int j = 1; j < LevelsDef; j++) begin
        for (int i = 0; i < MaxNodesDef; i++) begin
          e = jump[i*LevelsDef + j-1];
          if (e[16]) jump[i*LevelsDef + j] = jump[int'(e[15:0])*LevelsDef + j-1];
          else jump[i*LevelsDef + j] = '0;
        end
      end
      stale = 1'b0;
    endfunction

    function int unsigned walk_depth(int unsigned node, output int unsigned root);
      int unsigned d;
      logic [16:0] e;
      d = 0;
      for (int j = LevelsDef-1; j >= 0; j--) begin
        e = jump[node*LevelsDef + j];
        if (e[16]) begin
          node = e[15:0];
          d += (1 << j);
        end
      end
      root = node;
      return d;
    endfunction

    function int unsigned climb(int unsigned node, int unsigned steps);
      logic [16:0] e;
      for (int j = 0; j < LevelsDef; j++) begin
        if ((steps >> j) & 1) begin
          e = jump[node*LevelsDef + j];
          if (e[16]) node = e[15:0];
        end
      end
      return node;
    endfunction

    function lca_res_t common_ancestor(int unsigned u, int unsigned v);
      lca_res_t    r;
      int unsigned ru, rv, du, dv;
      logic [16:0] eu, ev;
      r = '0;
      if (stale) rebuild();
      du = walk_depth(u, ru);
      dv = walk_depth(v, rv);
      if (ru != rv) return r;
      if (du >= dv) u = climb(u, du - dv);
      else v = climb(v, dv - du);
      if (u == v) begin
        r.found = 1'b1;
        r.ancestor = u[NodeW-1:0];
        return r;
      end
      for (int j = LevelsDef-1; j >= 0; j--) begin
        eu = jump[u*LevelsDef + j];
        ev = jump[v*LevelsDef + j];
        if (eu[16] && ev[16] && eu != ev) begin
          u = eu[15:0];
          v = ev[15:0];
        end
      end
      eu = jump[u*LevelsDef];
      if (!eu[16]) return r;
      r.found = 1'b1;
      r.ancestor = eu[NodeW-1:0];
      return r;
    endfunction

    function void note_input(lca_item_t it);
      case (it.act)
        ActClear: clear_forest();
        ActEdge: begin
          jump[int'(it.b)*LevelsDef] = {1'b1, 2'b00, it.a};
          stale = 1'b1;
        end
        ActQuery: pending_q.insert(pending_q.size(), common_ancestor(it.a, it.b));
        default: ;
      endcase
    endfunction

    function void check_result(logic [NodeW-1:0] anc, logic fnd);
      lca_res_t want;
      if (pending_q.size() == 0) begin
        $error("result transfer with nothing expected: ancestor %0d found %0d", anc, fnd);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (fnd !== want.found) begin
        $error("found: expected %0d actual %0d", want.found, fnd);
        errors++;
      end
      if (anc !== want.ancestor) begin
        $error("ancestor: expected %0d actual %0d", want.ancestor, anc);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [ActW-1:0]  action_i = '0;
  logic [NodeW-1:0] node_a_i = '0;
  logic [NodeW-1:0] node_b_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [NodeW-1:0] ancestor_o;
  logic             found_o;

  lowest_common_ancestor_core u_top (.*);

  lca_scoreboard sb;
  lca_item_t     stim_q [$];
  bit            stim_done = 1'b0;
  int            results_seen = 0;
  longint        cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void add(logic [ActW-1:0] act, int unsigned a, int unsigned b);
    lca_item_t it;
    it.act = act;
    it.a = a[NodeW-1:0];
    it.b = b[NodeW-1:0];
    stim_q.insert(stim_q.size(), it);
  endfunction

  function automatic void random_phase(bit chain);
    int unsigned base, c, p;
    add(ActClear, $urandom, $urandom);
    base = $urandom_range(0, 16383 - 128);
    if (chain)
      for (int i = 1; i < 96; i++) add(ActEdge, base + i - 1, base + i);
    for (int k = 0; k < 250; k++) begin
      if ($urandom_range(0, 99) < 85) begin
        c = base + $urandom_range(1, 95);
        p = base + $urandom_range(0, c - base - 1);
        add(ActEdge, p, c);
      end else if ($urandom_range(0, 1)) begin
        add(ActEdge, $urandom, $urandom);
      end else begin
        c = base + $urandom_range(0, 95);
        add(ActEdge, c, base + $urandom_range(0, 95));
      end
      if ($urandom_range(0, 99) < 3) add(ActIgnored, $urandom, $urandom);
    end
    for (int k = 0; k < 650; k++) begin
      if ($urandom_range(0, 99) < 85)
        add(ActQuery, base + $urandom_range(0, 95), base + $urandom_range(0, 95));
      else
        add(ActQuery, $urandom, base + $urandom_range(0, 95));
      if ($urandom_range(0, 99) < 3) add(ActIgnored, $urandom, $urandom);
    end
  endfunction

  initial begin
    sb = new();
    // empty forest, ignored code
    add(ActClear, 0, 0);
    add(ActQuery, 0, 0);
    add(ActQuery, 5, 6);
    add(ActIgnored, 16383, 16383);
    // small tree, overwrite, top id, self edge, two-node cycle
    add(ActEdge, 0, 1);
    add(ActEdge, 1, 2);
    add(ActEdge, 1, 3);
    add(ActEdge, 0, 4);
    add(ActEdge, 3, 4);
    add(ActEdge, 16383, 0);
    add(ActEdge, 100, 100);
    add(ActEdge, 200, 201);
    add(ActEdge, 201, 200);
    add(ActQuery, 2, 4);
    add(ActQuery, 4, 2);
    add(ActQuery, 16383, 4);
    add(ActQuery, 16383, 16383);
    add(ActQuery, 100, 100);
    add(ActQuery, 100, 5);
    add(ActQuery, 200, 201);
    add(ActQuery, 200, 0);
    add(ActQuery, 2, 3);
    add(ActQuery, 14'h2aaa, 14'h1555);
    random_phase(1'b0);
    random_phase(1'b1);
  end

  // sender: bursts with gaps
  initial begin
    int idx, gap, burst;
    idx = 0;
    gap = 0;
    burst = $urandom_range(1, 40);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) begin
        sb.note_input(stim_q[idx]);
        idx++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (idx >= stim_q.size()) begin
          in_valid_i <= 1'b0;
          stim_done = 1'b1;
        end else if (gap > 0) begin
          gap--;
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          action_i <= stim_q[idx].act;
          node_a_i <= stim_q[idx].a;
          node_b_i <= stim_q[idx].b;
          burst--;
          if (burst <= 0) begin
            burst = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // receiver: stall pattern plus one long hold-off
  initial begin
    int mode, hold;
    bit held;
    mode = 0;
    hold = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(ancestor_o, found_o);
        results_seen++;
      end
      if (!held && results_seen == 40) begin
        held = 1'b1;
        hold = 600;
      end
      if (cycles % 64 == 0) mode = $urandom_range(0, 2);
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 99) < 30);
          default: out_stall_i <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/lca_pkg.sv
rtl/lca_mem.sv
rtl/lca_seq.sv
rtl/lowest_common_ancestor_core.sv
dv/tb.sv
